@@ sv/amcf_pkg.sv @@
// Shared types and constants for the audio module command framer.
// Holds the sequencer state type, frame byte values and frame byte positions.
// No dependencies.
`default_nettype none

package amcf_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRY,
        S_LOAD,
        S_SEND,
        S_REJECT
    } t_state;

    localparam logic [7:0] FRM_START    = 8'h7E;
    localparam logic [7:0] FRM_VERSION  = 8'hFF;
    localparam logic [7:0] FRM_LENGTH   = 8'h06;
    localparam logic [7:0] FRM_FEEDBACK = 8'h01;
    localparam logic [7:0] FRM_END      = 8'hEF;

    localparam logic [7:0]  CODE_VOLUME = 8'h06;
    localparam logic [15:0] VOLUME_MAX  = 16'd30;

    localparam logic        KIND_FRAME  = 1'b0;
    localparam logic        KIND_REJECT = 1'b1;

    localparam logic        REQ_ENQUEUE = 1'b0;

    localparam logic [15:0] CHK_SEED = 16'h0000 - ({8'h00, FRM_VERSION}
        + {8'h00, FRM_LENGTH} + {8'h00, FRM_FEEDBACK});

    localparam logic [3:0] POS_START    = 4'd0;
    localparam logic [3:0] POS_VERSION  = 4'd1;
    localparam logic [3:0] POS_LENGTH   = 4'd2;
    localparam logic [3:0] POS_CODE     = 4'd3;
    localparam logic [3:0] POS_FEEDBACK = 4'd4;
    localparam logic [3:0] POS_PARAM_HI = 4'd5;
    localparam logic [3:0] POS_PARAM_LO = 4'd6;
    localparam logic [3:0] POS_CHK_HI   = 4'd7;
    localparam logic [3:0] POS_CHK_LO   = 4'd8;
    localparam logic [3:0] POS_END      = 4'd9;

endpackage

`default_nettype wire

@@ sv/audio_module_command_framer.sv @@
// Top level of the audio module command framer: command queue, frame sequencer
// and output register. Depends on amcf_pkg.
//
// The block keeps a ring queue of QUEUE_DEPTH commands (8-bit code, 16-bit
// parameter) and a transmitter-ready flag. An enqueue request is stored, with
// the set-volume parameter clamped to 30, or rejected with a single result when
// the queue is full. A transmit-done request sets the ready flag. Whenever the
// flag is set and a command waits, the oldest command leaves as a ten-byte
// frame with a 16-bit additive checksum. One request is handled at a time and
// the input is stalled meanwhile; a reject waits out any output stall. The frame
// bytes come from the byte sequencer, which puts out one byte per cycle while
// the output is not stalled and runs the checksum through a single shared
// 16-bit subtractor; the queue memory read is registered.
`default_nettype none

module audio_module_command_framer #(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_command_code,
    input  wire logic [15:0] i_command_param,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_result_kind,
    output logic [7:0]       o_frame_byte,
    output logic             o_last_of_run
);
    import amcf_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    logic [23:0] mem [QUEUE_DEPTH];

    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          r_sender_ready, n_sender_ready;
    logic [3:0]    r_pos, n_pos;
    logic [15:0]   r_acc, n_acc;
    logic [23:0]   r_rd_data;
    logic          r_out_valid, n_out_valid;
    logic          r_out_kind, n_out_kind;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_last, n_out_last;

    logic          in_accept;
    logic          slot_free;
    logic          wr_en;
    logic          rd_en;
    logic [15:0]   param_clamped;
    logic [7:0]    cur_byte;
    logic [7:0]    sub_byte;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || !i_out_stall;
    assign param_clamped = (i_command_code == CODE_VOLUME && i_command_param > VOLUME_MAX)
                           ? VOLUME_MAX : i_command_param;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_tail] <= {i_command_code, param_clamped};
        end
        if (rd_en) begin
            r_rd_data <= mem[r_head];
        end
    end

    always_comb begin
        case (r_pos)
            POS_START:    cur_byte = FRM_START;
            POS_VERSION:  cur_byte = FRM_VERSION;
            POS_LENGTH:   cur_byte = FRM_LENGTH;
            POS_CODE:     cur_byte = r_rd_data[23:16];
            POS_FEEDBACK: cur_byte = FRM_FEEDBACK;
            POS_PARAM_HI: cur_byte = r_rd_data[15:8];
            POS_PARAM_LO: cur_byte = r_rd_data[7:0];
            POS_CHK_HI:   cur_byte = r_acc[15:8];
            POS_CHK_LO:   cur_byte = r_acc[7:0];
            POS_END:      cur_byte = FRM_END;
            default:      cur_byte = FRM_END;
        endcase
        sub_byte = (r_pos inside {POS_CODE, POS_PARAM_HI, POS_PARAM_LO})
                   ? cur_byte : 8'h00;
    end

    always_comb begin
        n_state        = r_state;
        n_head         = r_head;
        n_tail         = r_tail;
        n_count        = r_count;
        n_sender_ready = r_sender_ready;
        n_pos          = r_pos;
        n_acc          = r_acc;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_kind     = r_out_kind;
        n_out_byte     = r_out_byte;
        n_out_last     = r_out_last;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_req_type == REQ_ENQUEUE) begin
                        if (r_count == FULL_CNT) begin
                            n_state = S_REJECT;
                        end else begin
                            wr_en   = 1'b1;
                            n_tail  = (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
                            n_count = r_count + CW'(1);
                            n_state = S_TRY;
                        end
                    end else begin
                        n_sender_ready = 1'b1;
                        n_state        = S_TRY;
                    end
                end
            end
            S_TRY: begin
                if (r_sender_ready && r_count != '0) begin
                    rd_en          = 1'b1;
                    n_head         = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
                    n_count        = r_count - CW'(1);
                    n_sender_ready = 1'b0;
                    n_state        = S_LOAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LOAD: begin
                n_acc   = CHK_SEED;
                n_pos   = POS_START;
                n_state = S_SEND;
            end
            S_SEND: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_FRAME;
                    n_out_byte  = cur_byte;
                    n_out_last  = (r_pos == POS_END);
                    n_acc       = r_acc - {8'h00, sub_byte};
                    n_pos       = r_pos + 4'd1;
                    if (r_pos == POS_END) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_REJECT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_REJECT;
                    n_out_byte  = 8'h00;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_head         <= '0;
            r_tail         <= '0;
            r_count        <= '0;
            r_sender_ready <= 1'b1;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_head         <= n_head;
            r_tail         <= n_tail;
            r_count        <= n_count;
            r_sender_ready <= n_sender_ready;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_acc      <= n_acc;
        r_out_kind <= n_out_kind;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_frame_byte  = r_out_byte;
    assign o_last_of_run = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count exceeds depth");

    a_load_clears_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !r_sender_ready)
        else $error("frame started while sender still marked ready");

    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_REJECT) |-> (r_out_last && r_out_byte == 8'h00))
        else $error("malformed reject result");

    a_reject_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REJECT && $past(r_state) == S_IDLE) |-> (r_count == FULL_CNT))
        else $error("reject issued while queue not full");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for audio_module_command_framer: drives enqueue and
// transmit-done requests and checks every frame byte and reject result against
// a cycle-free model of the command queue. Depends on amcf_pkg and the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import amcf_pkg::*;

    localparam int   QUEUE_DEPTH  = 8;
    localparam int   RANDOM_ITEMS = 300;
    localparam int   IDLE_LIMIT   = 2000;
    localparam int   DRAIN_CYCLES = 20;
    localparam logic REQ_TX_DONE  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } t_result;

    class framer_model;
        t_result     expected_q[$];
        logic [23:0] store [QUEUE_DEPTH];
        int unsigned head;
        int unsigned tail;
        int unsigned count;
        bit          ready;
        int          errors;

        function new();
            head   = 0;
            tail   = 0;
            count  = 0;
            ready  = 1'b1;
            errors = 0;
        endfunction

        function void take_request(logic req, logic [7:0] code, logic [15:0] param);
            logic [15:0] value;
            logic [23:0] entry;
            logic [15:0] chk;
            logic [7:0]  frame [10];
            value = param;
            if (req == REQ_ENQUEUE) begin
                if (count >= QUEUE_DEPTH) begin
                    expected_q.push_back('{KIND_REJECT, 8'h00, 1'b1});
                    return;
                end
                if (code == CODE_VOLUME && value > VOLUME_MAX) begin
                    value = VOLUME_MAX;
                end
                store[tail] = {code, value};
                tail = (tail + 1) % QUEUE_DEPTH;
                count++;
            end else begin
                ready = 1'b1;
            end
            if (ready && count != 0) begin
                ready = 1'b0;
                entry = store[head];
                head = (head + 1) % QUEUE_DEPTH;
                count--;
                chk = 16'h0000 - (16'(FRM_VERSION) + 16'(FRM_LENGTH) + 16'(entry[23:16])
                    + 16'(FRM_FEEDBACK) + 16'(entry[15:8]) + 16'(entry[7:0]));
                frame[0] = FRM_START;
                frame[1] = FRM_VERSION;
                frame[2] = FRM_LENGTH;
                frame[3] = entry[23:16];
                frame[4] = FRM_FEEDBACK;
                frame[5] = entry[15:8];
                frame[6] = entry[7:0];
                frame[7] = chk[15:8];
                frame[8] = chk[7:0];
                frame[9] = FRM_END;
                for (int k = 0; k < 10; k++) begin
                    expected_q.push_back('{KIND_FRAME, frame[k], k == 9});
                end
            end
        endfunction

        function void check_result(logic kind, logic [7:0] data, logic last);
            t_result want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: result_kind %0d frame_byte %02h last_of_run %0d",
                    kind, data, last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (kind !== want.kind) begin
                $error("result_kind: expected %0d, actual %0d", want.kind, kind);
                errors++;
            end
            if (data !== want.data) begin
                $error("frame_byte: expected %02h, actual %02h", want.data, data);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_run: expected %0d, actual %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        i_req_type      = 1'b0;
    logic [7:0]  i_command_code  = 8'h00;
    logic [15:0] i_command_param = 16'h0000;
    logic        i_out_stall     = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_result_kind;
    logic [7:0]  o_frame_byte;
    logic        o_last_of_run;

    framer_model model = new();
    int          idle_cycles = 0;
    int          no_gap_left = 0;

    audio_module_command_framer #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_command_code (i_command_code),
        .i_command_param(i_command_param),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_kind  (o_result_kind),
        .o_frame_byte   (o_frame_byte),
        .o_last_of_run  (o_last_of_run)
    );

    always #2 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gap_left > 0) begin
            no_gap_left--;
            return 0;
        end
        if (r < 5) begin
            no_gap_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_request(input logic req, input logic [7:0] code,
                                input logic [15:0] param);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_command_code  <= code;
        i_command_param <= param;
        do @(posedge i_clk); while (o_in_stall);
        model.take_request(req, code, param);
    endtask

    // Output stall: short random bursts, rare long holds, and stall-free stretches.
    initial begin
        int r;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else if (r < 80) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else if (r < 90) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(4, 12)) @(posedge i_clk);
            end else if (r < 92) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(20, 40)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(50, 150)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            model.check_result(o_result_kind, o_frame_byte, o_last_of_run);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic        req;
        logic [7:0]  code;
        logic [15:0] param;
        int          sent;
        int          chunk;
        int          enq_pct;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Done with an empty queue while already ready, then a frame straight away.
        send_request(REQ_TX_DONE, 8'h00, 16'h0000);
        send_request(REQ_ENQUEUE, 8'h00, 16'h0000);

        // Transmitter busy: fill the queue, covering the volume clamp edges.
        send_request(REQ_ENQUEUE, CODE_VOLUME, 16'hFFFF);
        send_request(REQ_ENQUEUE, CODE_VOLUME, 16'd31);
        send_request(REQ_ENQUEUE, CODE_VOLUME, 16'd30);
        send_request(REQ_ENQUEUE, CODE_VOLUME, 16'd29);
        send_request(REQ_ENQUEUE, CODE_VOLUME, 16'h0000);
        send_request(REQ_ENQUEUE, 8'hFF, 16'hFFFF);
        send_request(REQ_ENQUEUE, 8'h07, 16'hFFFF);
        send_request(REQ_ENQUEUE, 8'hA5, 16'h5A5A);

        // Queue full: both are rejected.
        send_request(REQ_ENQUEUE, 8'h5A, 16'hA5A5);
        send_request(REQ_ENQUEUE, CODE_VOLUME, 16'h0001);

        // Drain all eight, then done on an empty queue and done while ready.
        repeat (QUEUE_DEPTH + 2) send_request(REQ_TX_DONE, 8'hFF, 16'hFFFF);
        send_request(REQ_ENQUEUE, 8'h3C, 16'hC3C3);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 30;
                1:       enq_pct = 55;
                default: enq_pct = 85;
            endcase
            chunk = $urandom_range(8, 40);
            repeat (chunk) begin
                req = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQUEUE : REQ_TX_DONE;
                code = ($urandom_range(0, 3) == 0) ? CODE_VOLUME : 8'($urandom_range(0, 255));
                case ($urandom_range(0, 9))
                    0:       param = 16'd29;
                    1:       param = 16'd30;
                    2:       param = 16'd31;
                    3:       param = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                    default: param = 16'($urandom_range(0, 65535));
                endcase
                send_request(req, code, param);
                sent++;
            end
        end
        i_in_valid <= 1'b0;

        while (model.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (model.errors == 0 && model.expected_q.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
